[hw/rtl/parabolic_peak_interpolator_defines.svh]
// ----------------------------------------------------------------------------
// Parabolic peak interpolator assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PARABOLIC_PEAK_INTERPOLATOR_DEFINES_SVH
`define PARABOLIC_PEAK_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define PPI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ppi_pkg.sv]
// ----------------------------------------------------------------------------
// Parabolic peak interpolator package
// Sequencer state type shared by the block and its checks.
// ----------------------------------------------------------------------------
package ppi_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

endpackage

[hw/rtl/parabolic_peak_interpolator.sv]
// Non-peak item: taken with no result, ready again next cycle.
// Peak item: one square (S_MUL), SAMPLE_WIDTH+2 restoring divide steps (S_DIV),
//   then one add into the output register (S_OUT), once a held result is taken.
// No new item is taken until a peak item's result has been loaded.
// A held result does not block the next item unless another peak finishes first.
// Synchronous active-low reset clears sample history, fill count and handshake.
// ----------------------------------------------------------------------------
// Parabolic peak interpolator
// Three-point parabola vertex height at each strict local maximum of a
// signed sample stream, using a shared serial divider.
// ----------------------------------------------------------------------------
`include "parabolic_peak_interpolator_defines.svh"

module parabolic_peak_interpolator #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [SAMPLE_WIDTH-1:0] sample_in, zero padding above
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // [SAMPLE_WIDTH-1:0] peak_height, zero padding above
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int TW  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int XW  = W + 4;          // working width for D and E
    localparam int EW  = W + 3;          // E is positive at a peak, below 2^(W+2)
    localparam int RW  = W + 4;          // remainder and divisor width
    localparam int QW  = W + 2;          // quotient bits
    localparam int CW  = $clog2(QW);
    localparam int SW  = W + 3;          // final sum width
    localparam logic [SW-1:0] SMAX = {4'b0000, {(W-1){1'b1}}};

    ppi_pkg::t_state r_state, n_state;

    logic signed [W-1:0]  r_older;
    logic signed [W-1:0]  r_middle;
    logic [1:0]           r_fill;
    logic signed [W-1:0]  r_a;
    logic [EW-1:0]        r_e;
    logic [RW-1:0]        r_den;
    logic [RW-1:0]        r_rem;
    logic [QW-1:0]        r_dvd;
    logic [CW-1:0]        r_cnt;
    logic                 r_out_valid;
    logic [W-1:0]         r_out_data;

    logic signed [W-1:0]  sample;
    logic signed [XW-1:0] ax, bx, cx, dd, ee, dmag;
    logic                 accept, peak, load_out;
    logic [RW:0]          trial, diff;
    logic [2*EW-1:0]      prod;
    logic signed [SW-1:0] sum;

    assign sample = s_axis_tdata[W-1:0];
    assign accept = s_axis_tvalid && s_axis_tready;

    assign ax   = XW'(r_older);
    assign bx   = XW'(r_middle);
    assign cx   = XW'(sample);
    assign dd   = ax - (bx <<< 1) + cx;
    assign ee   = (bx <<< 2) - ax - (ax <<< 1) - cx;
    assign dmag = -dd;
    assign peak = (r_fill == 2'd2) && (r_middle > r_older) && (r_middle > sample);

    // shared unit: one multiply, then one compare-subtract per quotient bit
    assign prod  = r_e * r_e;
    assign trial = {r_rem, r_dvd[QW-1]};
    assign diff  = trial - {1'b0, r_den};

    assign sum = SW'(r_a) + $signed({1'b0, r_dvd});

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        case (r_state)
            ppi_pkg::S_IDLE: begin
                // no item is taken while reset is held
                s_axis_tready = i_rst_n;
                if (s_axis_tvalid && peak) begin
                    n_state = ppi_pkg::S_MUL;
                end
            end
            ppi_pkg::S_MUL: begin
                n_state = ppi_pkg::S_DIV;
            end
            ppi_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ppi_pkg::S_OUT;
                end
            end
            ppi_pkg::S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ppi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppi_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppi_pkg::S_IDLE;
            r_older     <= '0;
            r_middle    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_older  <= r_middle;
                r_middle <= sample;
                if (r_fill != 2'd2) begin
                    r_fill <= r_fill + 2'd1;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && peak) begin
            r_a   <= r_older;
            r_e   <= ee[EW-1:0];
            r_den <= {dmag[W:0], 3'b000};
        end
        case (r_state)
            ppi_pkg::S_MUL: begin
                // top of the square seeds the remainder; it is already below the divisor
                r_rem <= prod[2*EW-1:QW];
                r_dvd <= prod[QW-1:0];
                r_cnt <= CW'(QW - 1);
            end
            ppi_pkg::S_DIV: begin
                if (diff[RW]) begin
                    r_rem <= trial[RW-1:0];
                end else begin
                    r_rem <= diff[RW-1:0];
                end
                r_dvd <= {r_dvd[QW-2:0], ~diff[RW]};
                r_cnt <= r_cnt - CW'(1);
            end
            default: begin
            end
        endcase
        if (load_out) begin
            r_out_data <= (sum > $signed(SMAX)) ? SMAX[W-1:0] : sum[W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TW'(r_out_data);

    `PPI_ASSERT_IMP(a_rem_below_den, r_state == ppi_pkg::S_DIV, r_rem < r_den, "remainder not below divisor")
    `PPI_ASSERT_IMP(a_den_nonzero, r_state != ppi_pkg::S_IDLE, r_den != '0, "zero divisor in flight")
    `PPI_ASSERT_NXT(a_mul_to_div, r_state == ppi_pkg::S_MUL, r_state == ppi_pkg::S_DIV && r_cnt == CW'(QW - 1), "divide did not start after square")
    `PPI_ASSERT_IMP(a_result_source, $rose(r_out_valid), $past(r_state) == ppi_pkg::S_OUT, "result without finished divide")

endmodule

[tb/tb_parabolic_peak_interpolator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Parabolic peak interpolator testbench
// Streams signed samples into the block and predicts each vertex height at
// every strict local maximum. The prediction is checked height by height
// against the output stream, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_parabolic_peak_interpolator;

    localparam int SAMPLE_W     = 24;
    localparam int DATA_W       = ((SAMPLE_W + 7) / 8) * 8;
    localparam longint TOP      = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint BOTTOM   = -(longint'(1) <<< (SAMPLE_W - 1));
    localparam int DRAIN_CYCLES = 2 * (SAMPLE_W + 3) + 10;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 1000;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;  // [23:0] sample_in
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;        // [23:0] peak_height

    parabolic_peak_interpolator #(.SAMPLE_WIDTH(SAMPLE_W)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // predictor state: sample history as the block holds it
    logic signed [SAMPLE_W-1:0] hist_older  = '0;
    logic signed [SAMPLE_W-1:0] hist_middle = '0;
    int                         hist_fill   = 0;
    logic [SAMPLE_W-1:0]        expected_heights[$];

    int  error_count   = 0;
    int  samples_sent  = 0;
    int  peaks_checked = 0;
    int  cycle_count   = 0;
    bit  steady_flow   = 1'b0;  // no gaps on either side while set

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // vertex height a + floor(E*E / (8*|D|)), saturated at the top
    function automatic void take_sample(input logic [SAMPLE_W-1:0] raw);
        logic signed [SAMPLE_W-1:0] a, b, c;
        longint dd, ee, den, q, h;
        a = hist_older;
        b = hist_middle;
        c = raw;
        if (hist_fill >= 2 && b > a && b > c) begin
            dd  = longint'(a) - 2 * longint'(b) + longint'(c);
            ee  = 4 * longint'(b) - 3 * longint'(a) - longint'(c);
            den = -8 * dd;
            q   = (ee * ee) / den;
            h   = longint'(a) + q;
            if (h > TOP)
                h = TOP;
            expected_heights.push_back(h[SAMPLE_W-1:0]);
        end
        hist_older  = b;
        hist_middle = c;
        if (hist_fill < 2)
            hist_fill++;
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp_sample(input longint v);
        if (v > TOP)
            return TOP[SAMPLE_W-1:0];
        if (v < BOTTOM)
            return BOTTOM[SAMPLE_W-1:0];
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(value);
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1)
            @(posedge i_clk);
        take_sample(value);
        samples_sent++;
    endtask

    // hold the input idle until every predicted height has come out
    task automatic wait_for_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_heights.size() != 0)
            @(posedge i_clk);
    endtask

    // receiver: random stall per item, checks each accepted height
    initial begin
        int stall;
        logic [SAMPLE_W-1:0] want;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1)
                @(posedge i_clk);
            if (expected_heights.size() == 0) begin
                report_mismatch($sformatf("unexpected height %0d",
                                          $signed(m_axis_tdata[SAMPLE_W-1:0])));
            end else begin
                want = expected_heights.pop_front();
                peaks_checked++;
                if (m_axis_tdata[SAMPLE_W-1:0] !== want)
                    report_mismatch($sformatf("peak_height got %0d want %0d",
                                              $signed(m_axis_tdata[SAMPLE_W-1:0]),
                                              $signed(want)));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_parabolic_peak_interpolator NOT OK");
            $finish;
        end
    end

    // a clear peak as the first sample must be held back during warm-up
    task automatic test_warm_up();
        send_sample(clamp_sample(1000));
        send_sample(clamp_sample(-1000));
        send_sample(clamp_sample(-2000));
    endtask

    // equal neighbours are not peaks
    task automatic test_ties();
        send_sample(clamp_sample(10));
        send_sample(clamp_sample(20));
        send_sample(clamp_sample(20));
        send_sample(clamp_sample(10));
        send_sample(clamp_sample(30));
        send_sample(clamp_sample(30));
        send_sample(clamp_sample(30));
        send_sample(clamp_sample(40));
        send_sample(clamp_sample(20));
    endtask

    // full-scale swings: top saturation, peaks at both ends, smallest peak
    task automatic test_extremes();
        send_sample(clamp_sample(BOTTOM));
        send_sample(clamp_sample(TOP));
        send_sample(clamp_sample(BOTTOM));
        send_sample(clamp_sample(TOP - 1));
        send_sample(clamp_sample(TOP));
        send_sample(clamp_sample(BOTTOM));
        send_sample(clamp_sample(BOTTOM + 1));
        send_sample(clamp_sample(BOTTOM));
        send_sample(clamp_sample(-1));
        send_sample(clamp_sample(0));
        send_sample(clamp_sample(-1));
        send_sample(clamp_sample(TOP));
        send_sample(clamp_sample(TOP - 1));
    endtask

    // rising then falling runs with random slope scale, plus raw noise
    task automatic test_random_peaks(input int count);
        longint level;
        longint step;
        int     scale, run, i, limit;
        limit = samples_sent + count;
        level = longint'($signed($urandom_range(0, 32'hFFFFFF) << 8)) >>> 8;
        while (samples_sent < limit) begin
            if ($urandom_range(0, 9) < 2) begin
                send_sample(SAMPLE_W'($urandom));
                level = longint'($signed(hist_middle));
            end else begin
                scale = $urandom_range(0, 22);
                run   = $urandom_range(1, 4);
                for (i = 0; i < run; i++) begin
                    step  = longint'($urandom_range(0, 1 << scale));
                    level = longint'($signed(clamp_sample(level + step)));
                    send_sample(level[SAMPLE_W-1:0]);
                end
                run = $urandom_range(1, 4);
                for (i = 0; i < run; i++) begin
                    step  = longint'($urandom_range(0, 1 << scale));
                    level = longint'($signed(clamp_sample(level - step)));
                    send_sample(level[SAMPLE_W-1:0]);
                end
            end
            if ($urandom_range(0, 49) == 0)
                steady_flow = ~steady_flow;
        end
        steady_flow = 1'b0;
    endtask

    // independent full-range samples: every bit toggles, peaks about a third
    task automatic test_random_noise(input int count);
        int i;
        steady_flow = 1'b1;
        for (i = 0; i < count; i++) begin
            if (i == count / 2)
                steady_flow = 1'b0;
            send_sample(SAMPLE_W'($urandom));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_warm_up();
        test_ties();
        test_extremes();
        wait_for_drain();
        test_random_peaks(RANDOM_ITEMS * 7 / 10);
        wait_for_drain();
        test_random_noise(RANDOM_ITEMS * 3 / 10);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("samples sent: %0d, peak heights checked: %0d", samples_sent, peaks_checked);
        $display("covered warm-up, ties, full-scale saturation, humps and noise");
        if (error_count == 0) begin
            $display("tb_parabolic_peak_interpolator OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("tb_parabolic_peak_interpolator NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ppi_pkg.sv
hw/rtl/parabolic_peak_interpolator.sv
tb/tb_parabolic_peak_interpolator.sv
